### rtl/sags_pkg.sv
// Shared types and constants for the oscilloscope autoset gear selector.
`timescale 1ns / 1ps

package sags_pkg;

  localparam int NUM_TIME_GEARS = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPAN_GEAR0 = 2'd0;
  localparam logic [1:0] CFG_SPAN_GEAR1 = 2'd1;
  localparam logic [1:0] CFG_SPAN_GEAR2 = 2'd2;
  localparam logic [1:0] CFG_CAL_FACTOR = 2'd3;

  localparam logic [15:0] SPAN_GEAR0_RST = 16'd16000;
  localparam logic [15:0] SPAN_GEAR1_RST = 16'd1600;
  localparam logic [15:0] SPAN_GEAR2_RST = 16'd160;
  localparam logic [15:0] CAL_FACTOR_RST = 16'd16384;

  localparam logic [1:0] VOLT_GEAR_MAX = 2'd2;
  localparam logic [3:0] TIME_GEAR_MAX = 4'd15;
  localparam logic [4:0] TIME_GEAR_STEP = 5'd3;

  // Frequencies at or below this (10 Hz in millihertz) take the slow path.
  localparam logic [31:0] FAST_FREQ_MIN = 32'd10000;

  // A step qualifies once step_us * freq_mhz reaches this product.
  localparam longint TargetProduct = 64'd350000000;

  localparam longint StepUs [NUM_TIME_GEARS] = '{
    10, 20, 50, 100, 200, 500, 1000, 2000,
    5000, 10000, 20000, 50000, 100000, 200000, 500000, 1000000
  };

  // Smallest frequency for which each step qualifies.
  localparam logic [31:0] STEP_FREQ_MIN [NUM_TIME_GEARS] = '{
    32'((TargetProduct + StepUs[0] - 1) / StepUs[0]),
    32'((TargetProduct + StepUs[1] - 1) / StepUs[1]),
    32'((TargetProduct + StepUs[2] - 1) / StepUs[2]),
    32'((TargetProduct + StepUs[3] - 1) / StepUs[3]),
    32'((TargetProduct + StepUs[4] - 1) / StepUs[4]),
    32'((TargetProduct + StepUs[5] - 1) / StepUs[5]),
    32'((TargetProduct + StepUs[6] - 1) / StepUs[6]),
    32'((TargetProduct + StepUs[7] - 1) / StepUs[7]),
    32'((TargetProduct + StepUs[8] - 1) / StepUs[8]),
    32'((TargetProduct + StepUs[9] - 1) / StepUs[9]),
    32'((TargetProduct + StepUs[10] - 1) / StepUs[10]),
    32'((TargetProduct + StepUs[11] - 1) / StepUs[11]),
    32'((TargetProduct + StepUs[12] - 1) / StepUs[12]),
    32'((TargetProduct + StepUs[13] - 1) / StepUs[13]),
    32'((TargetProduct + StepUs[14] - 1) / StepUs[14]),
    32'((TargetProduct + StepUs[15] - 1) / StepUs[15])
  };

  typedef struct packed {
    logic [15:0]        vpp_mv;
    logic signed [15:0] avg_mv;
    logic [31:0]        freq_mhz;
    logic [1:0]         cur_volt_gear;
    logic [3:0]         cur_time_gear;
  } meas_t;

  typedef struct packed {
    logic [15:0] span_gear0_mv;
    logic [15:0] span_gear1_mv;
    logic [15:0] span_gear2_mv;
    logic [15:0] cal_factor_q14;
  } cfg_regs_t;

  typedef struct packed {
    meas_t       meas;
    logic [1:0]  eff_gear;
    logic [31:0] denom;
  } mul_stage_t;

  typedef struct packed {
    logic signed [15:0] avg_mv;
    logic [1:0]         cur_volt_gear;
    logic [1:0]         eff_gear;
    logic [3:0]         cur_time_gear;
    logic [21:0]        vpp_x33;
    logic [24:0]        vpp_x330;
    logic [27:0]        vpp_x3300;
    logic [36:0]        denom_x31;
    logic               fast;
    logic [3:0]         fast_gear;
  } scale_stage_t;

  typedef struct packed {
    logic [1:0]         next_volt_gear;
    logic               volt_gear_changed;
    logic signed [15:0] trigger_level_mv;
    logic [3:0]         next_time_gear;
    logic               time_gear_changed;
  } result_t;

endpackage

### rtl/sags_mul.sv
// First stage: span selection and span times calibration product.
`timescale 1ns / 1ps

module sags_mul import sags_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  meas_t      meas,
  input  cfg_regs_t  cfg,
  output mul_stage_t stage_r
);

  logic [1:0]  eff_gear;
  logic [15:0] span_sel;
  mul_stage_t  stage_nxt;

  always_comb begin
    eff_gear = (meas.cur_volt_gear > VOLT_GEAR_MAX) ? VOLT_GEAR_MAX : meas.cur_volt_gear;
    case (eff_gear)
      2'd0:    span_sel = cfg.span_gear0_mv;
      2'd1:    span_sel = cfg.span_gear1_mv;
      default: span_sel = cfg.span_gear2_mv;
    endcase
    stage_nxt.meas     = meas;
    stage_nxt.eff_gear = eff_gear;
    stage_nxt.denom    = {16'd0, span_sel} * {16'd0, cfg.cal_factor_q14};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

### rtl/sags_scale.sv
// Second stage: constant scaling of both sides and timebase threshold search.
`timescale 1ns / 1ps

module sags_scale import sags_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  mul_stage_t   stage,
  output scale_stage_t stage_r
);

  scale_stage_t stage_nxt;
  logic [3:0]   fast_gear;

  // Thresholds fall with the index, so the first qualifying step wins.
  always_comb begin
    fast_gear = TIME_GEAR_MAX;
    for (int i = NUM_TIME_GEARS - 1; i >= 0; i--) begin
      if (stage.meas.freq_mhz >= STEP_FREQ_MIN[i]) begin
        fast_gear = 4'(i);
      end
    end
  end

  always_comb begin
    stage_nxt.avg_mv        = stage.meas.avg_mv;
    stage_nxt.cur_volt_gear = stage.meas.cur_volt_gear;
    stage_nxt.eff_gear      = stage.eff_gear;
    stage_nxt.cur_time_gear = stage.meas.cur_time_gear;
    stage_nxt.vpp_x33       = {6'd0, stage.meas.vpp_mv} * 22'd33;
    stage_nxt.vpp_x330      = {9'd0, stage.meas.vpp_mv} * 25'd330;
    stage_nxt.vpp_x3300     = {12'd0, stage.meas.vpp_mv} * 28'd3300;
    stage_nxt.denom_x31     = {stage.denom, 5'd0} - {5'd0, stage.denom};
    stage_nxt.fast          = stage.meas.freq_mhz > FAST_FREQ_MIN;
    stage_nxt.fast_gear     = fast_gear;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

### rtl/sags_decide.sv
// Third stage: swing comparisons, gear decisions and the result register.
`timescale 1ns / 1ps

module sags_decide import sags_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  scale_stage_t stage,
  output result_t      result_r
);

  logic       above_hi;
  logic       below_lo;
  logic       below_mid;
  logic [1:0] volt_nxt;
  logic [4:0] slow_sum;
  logic [3:0] time_nxt;
  result_t    result_nxt;

  always_comb begin
    above_hi  = {1'b0, stage.vpp_x33, 14'd0} > stage.denom_x31;
    below_lo  = {stage.vpp_x3300, 14'd0} < {5'd0, stage.denom_x31};
    below_mid = {stage.vpp_x330, 14'd0} < {2'd0, stage.denom_x31};

    volt_nxt = stage.eff_gear;
    if (above_hi) begin
      volt_nxt = 2'd0;
    end else if (stage.eff_gear == 2'd0 && below_lo) begin
      volt_nxt = VOLT_GEAR_MAX;
    end else if (below_mid && stage.eff_gear < VOLT_GEAR_MAX) begin
      volt_nxt = stage.eff_gear + 2'd1;
    end

    slow_sum = {1'b0, stage.cur_time_gear} + TIME_GEAR_STEP;
    if (stage.fast) begin
      time_nxt = stage.fast_gear;
    end else if (slow_sum > {1'b0, TIME_GEAR_MAX}) begin
      time_nxt = TIME_GEAR_MAX;
    end else begin
      time_nxt = slow_sum[3:0];
    end

    result_nxt.next_volt_gear    = volt_nxt;
    result_nxt.volt_gear_changed = volt_nxt != stage.cur_volt_gear;
    result_nxt.trigger_level_mv  = stage.avg_mv;
    result_nxt.next_time_gear    = time_nxt;
    result_nxt.time_gear_changed = time_nxt != stage.cur_time_gear;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

endmodule

### rtl/scope_autoset_gear_select_top.sv
// Top level of the oscilloscope autoset gear selector: config, pipeline control, checks.
//
//   Channel  Direction  Handshake         Payload
//   in_      input      valid / stall     vpp, avg, freq, current gears
//   out_     output     valid / stall     next gears, changed flags, trigger level
//   cfg_     input      valid / ready     2-bit register index, 16-bit data
//
// One request enters per cycle while in_stall is low.
// The depth is set by the three register stages: multiply, constant scale, compare.
// Reset clears the stage valid bits and loads the default spans and calibration.
// A stalled output holds its result; earlier stages keep filling bubbles meanwhile.
// The configuration port is always ready.
`timescale 1ns / 1ps

module scope_autoset_gear_select_top import sags_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_vpp_mv,
  input  logic signed [15:0] in_avg_mv,
  input  logic [31:0]        in_freq_mhz,
  input  logic [1:0]         in_cur_volt_gear,
  input  logic [3:0]         in_cur_time_gear,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_next_volt_gear,
  output logic               out_volt_gear_changed,
  output logic signed [15:0] out_trigger_level_mv,
  output logic [3:0]         out_next_time_gear,
  output logic               out_time_gear_changed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_regs_t    cfg_r;
  cfg_regs_t    cfg_nxt;
  meas_t        meas;
  mul_stage_t   mul_stage;
  scale_stage_t scale_stage;
  result_t      result;
  logic         v1_r, v2_r, v3_r;
  logic         v1_nxt, v2_nxt, v3_nxt;
  logic         en1, en2, en3;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPAN_GEAR0: cfg_nxt.span_gear0_mv  = cfg_data;
        CFG_SPAN_GEAR1: cfg_nxt.span_gear1_mv  = cfg_data;
        CFG_SPAN_GEAR2: cfg_nxt.span_gear2_mv  = cfg_data;
        CFG_CAL_FACTOR: cfg_nxt.cal_factor_q14 = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span_gear0_mv  <= SPAN_GEAR0_RST;
      cfg_r.span_gear1_mv  <= SPAN_GEAR1_RST;
      cfg_r.span_gear2_mv  <= SPAN_GEAR2_RST;
      cfg_r.cal_factor_q14 <= CAL_FACTOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Each stage advances when it is empty or the stage after it advances.
  always_comb begin
    en3      = !v3_r || !out_stall;
    en2      = !v2_r || en3;
    en1      = !v1_r || en2;
    in_stall = !en1;
    v1_nxt   = en1 ? in_valid : v1_r;
    v2_nxt   = en2 ? v1_r : v2_r;
    v3_nxt   = en3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign meas.vpp_mv        = in_vpp_mv;
  assign meas.avg_mv        = in_avg_mv;
  assign meas.freq_mhz      = in_freq_mhz;
  assign meas.cur_volt_gear = in_cur_volt_gear;
  assign meas.cur_time_gear = in_cur_time_gear;

  sags_mul u_mul (
    .clk     (clk),
    .en      (en1),
    .meas    (meas),
    .cfg     (cfg_r),
    .stage_r (mul_stage)
  );

  sags_scale u_scale (
    .clk     (clk),
    .en      (en2),
    .stage   (mul_stage),
    .stage_r (scale_stage)
  );

  sags_decide u_decide (
    .clk      (clk),
    .en       (en3),
    .stage    (scale_stage),
    .result_r (result)
  );

  assign out_valid             = v3_r;
  assign out_next_volt_gear    = result.next_volt_gear;
  assign out_volt_gear_changed = result.volt_gear_changed;
  assign out_trigger_level_mv  = result.trigger_level_mv;
  assign out_next_time_gear    = result.next_time_gear;
  assign out_time_gear_changed = result.time_gear_changed;

  a_vert_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_volt_gear <= VOLT_GEAR_MAX)
    else $error("vertical gear out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en2) |=> v2_r)
    else $error("stalled second stage lost its request");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en2) |=> v2_r)
    else $error("request did not advance into the second stage");

endmodule
